// ===== rtl/basp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// basp_pkg
// Shared types, character codes and result kinds of the alignment trace
// string parser.
// ----------------------------------------------------------------------------
package basp_pkg;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 96;
    localparam int RESQ_DEPTH_DEFAULT = 4;

    localparam logic [1:0] KIND_INTRON  = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    localparam logic [7:0] SYM_ZERO   = 8'h30;
    localparam logic [7:0] SYM_NINE   = 8'h39;
    localparam logic [7:0] SYM_PCT    = 8'h25;
    localparam logic [7:0] SYM_UNDER  = 8'h5F;
    localparam logic [7:0] SYM_CARET  = 8'h5E;
    localparam logic [7:0] SYM_A      = 8'h41;
    localparam logic [7:0] SYM_T      = 8'h54;
    localparam logic [7:0] SYM_G      = 8'h47;
    localparam logic [7:0] SYM_C      = 8'h43;
    localparam logic [7:0] SYM_N      = 8'h4E;
    localparam logic [7:0] SYM_DASH   = 8'h2D;

    localparam logic [23:0] RUN_MAX  = 24'hFFFFFF;
    localparam logic [15:0] ERR_MAX  = 16'hFFFF;
    localparam logic [7:0]  INTR_MAX = 8'hFF;

    typedef struct packed {
        logic [7:0]  symbol;
        logic        first_of_read;
        logic        last_of_read;
        logic [30:0] start_position;
        logic        reverse_strand;
        logic        read_is_first;
    } input_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] coord_first;
        logic signed [31:0] coord_second;
        logic [15:0]        error_count;
        logic [7:0]         intron_count;
        logic               mate_one;
        logic               last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res_a;
        result_t    res_b;
    } push_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= SYM_ZERO) && (c <= SYM_NINE);
    endfunction

    function automatic logic is_base(input logic [7:0] c);
        return (c == SYM_A) || (c == SYM_T) || (c == SYM_G) || (c == SYM_C) ||
               (c == SYM_N) || (c == SYM_DASH);
    endfunction

endpackage

// ===== rtl/basp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// basp_step
// Input register, parse state and the single-cycle parse step that turns one
// trace character into zero, one or two results.
// ----------------------------------------------------------------------------
module basp_step
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  basp_pkg::input_t  in_item,
    input  logic              room,
    output basp_pkg::push_t   push
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_RUN    = 3'd1;
    localparam logic [2:0] PH_DEL    = 3'd2;
    localparam logic [2:0] PH_INS    = 3'd3;
    localparam logic [2:0] PH_INTRON = 3'd4;
    localparam logic [2:0] PH_SUB2   = 3'd5;

    logic              enable_reg;
    logic              item_valid_reg;
    basp_pkg::input_t  item_reg;
    logic              fire;

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] position_reg, position_next;
    logic [23:0] run_reg, run_next;
    logic [15:0] err_reg, err_next;
    logic [7:0]  intr_reg, intr_next;
    logic        up_reg, up_next;
    logic        mate_reg, mate_next;
    logic        discard_reg, discard_next;

    logic [2:0]  ph_eff;
    logic [31:0] pos_eff;
    logic [23:0] run_eff;
    logic [15:0] err_eff;
    logic [7:0]  intr_eff;
    logic        up_eff;
    logic        mate_eff;
    logic        disc_eff;

    logic [7:0]  sym;
    logic        sym_digit;
    logic        sym_base;
    logic [27:0] acc_prod;
    logic [23:0] acc_val;
    logic [23:0] move_amt;
    logic [31:0] pos_moved;
    logic [31:0] far_edge;
    logic [15:0] err_add;
    logic [16:0] err_sum;
    logic [15:0] err_sat;
    logic [7:0]  intr_inc;
    logic        bad;
    logic        rec;
    logic        summ;
    logic [31:0] b1;
    logic [31:0] b2;

    assign fire     = item_valid_reg && room;
    assign in_ready = !item_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                enable_reg <= cfg_wr_data;
            end
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign sym       = item_reg.symbol;
    assign sym_digit = basp_pkg::is_digit(sym);
    assign sym_base  = basp_pkg::is_base(sym);

    always_comb
    begin
        if (item_reg.first_of_read)
        begin
            ph_eff   = PH_RUN;
            pos_eff  = {1'b0, item_reg.start_position};
            run_eff  = '0;
            err_eff  = '0;
            intr_eff = '0;
            up_eff   = !item_reg.reverse_strand;
            mate_eff = item_reg.read_is_first;
            disc_eff = 1'b0;
        end
        else
        begin
            ph_eff   = phase_reg;
            pos_eff  = position_reg;
            run_eff  = run_reg;
            err_eff  = err_reg;
            intr_eff = intr_reg;
            up_eff   = up_reg;
            mate_eff = mate_reg;
            disc_eff = discard_reg;
        end
    end

    assign acc_prod = {1'b0, run_eff, 3'b000} + {3'b000, run_eff, 1'b0} + {24'd0, sym[3:0]};
    assign acc_val  = (|acc_prod[27:24]) ? basp_pkg::RUN_MAX : acc_prod[23:0];

    assign move_amt  = (ph_eff == PH_SUB2) ? 24'd1 : run_eff;
    assign pos_moved = up_eff ? pos_eff + {8'd0, move_amt} : pos_eff - {8'd0, move_amt};
    assign far_edge  = up_eff ? pos_moved - 32'd1 : pos_moved + 32'd1;

    assign err_add = (ph_eff == PH_SUB2) ? 16'd1 :
                     ((|run_eff[23:16]) ? basp_pkg::ERR_MAX : run_eff[15:0]);
    assign err_sum = {1'b0, err_eff} + {1'b0, err_add};
    assign err_sat = err_sum[16] ? basp_pkg::ERR_MAX : err_sum[15:0];

    assign intr_inc = (intr_eff == basp_pkg::INTR_MAX) ? intr_eff : intr_eff + 8'd1;

    assign b1 = mate_eff ? far_edge : pos_eff;
    assign b2 = mate_eff ? pos_eff : far_edge;

    always_comb
    begin
        phase_next    = ph_eff;
        position_next = pos_eff;
        run_next      = run_eff;
        err_next      = err_eff;
        intr_next     = intr_eff;
        up_next       = up_eff;
        mate_next     = mate_eff;
        discard_next  = disc_eff;
        bad           = 1'b0;
        rec           = 1'b0;
        summ          = 1'b0;
        if (ph_eff == PH_IDLE)
        begin
            phase_next = PH_IDLE;
        end
        else if (disc_eff)
        begin
            if (item_reg.last_of_read)
            begin
                phase_next   = PH_IDLE;
                discard_next = 1'b0;
            end
        end
        else
        begin
            unique case (ph_eff)
                PH_RUN:
                begin
                    if (sym_digit)
                    begin
                        run_next = acc_val;
                    end
                    else
                    begin
                        position_next = pos_moved;
                        run_next      = '0;
                        if (sym == basp_pkg::SYM_PCT)
                        begin
                            phase_next = PH_DEL;
                        end
                        else if (sym == basp_pkg::SYM_UNDER)
                        begin
                            phase_next = PH_INS;
                        end
                        else if (sym == basp_pkg::SYM_CARET)
                        begin
                            phase_next = PH_INTRON;
                        end
                        else if (sym_base)
                        begin
                            phase_next = PH_SUB2;
                        end
                        else
                        begin
                            bad = 1'b1;
                        end
                    end
                end
                PH_DEL:
                begin
                    if (sym_digit)
                    begin
                        run_next = acc_val;
                    end
                    else if (sym == basp_pkg::SYM_PCT)
                    begin
                        run_next   = '0;
                        phase_next = PH_RUN;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                PH_INS:
                begin
                    if (sym_digit)
                    begin
                        run_next = acc_val;
                    end
                    else if (sym == basp_pkg::SYM_UNDER)
                    begin
                        err_next      = err_sat;
                        position_next = pos_moved;
                        run_next      = '0;
                        phase_next    = PH_RUN;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                PH_INTRON:
                begin
                    if (sym_digit)
                    begin
                        run_next = acc_val;
                    end
                    else if (sym == basp_pkg::SYM_CARET)
                    begin
                        intr_next     = intr_inc;
                        rec           = enable_reg;
                        position_next = pos_moved;
                        run_next      = '0;
                        phase_next    = PH_RUN;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                PH_SUB2:
                begin
                    if (sym_base)
                    begin
                        err_next      = err_sat;
                        position_next = pos_moved;
                        phase_next    = PH_RUN;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                default:
                begin
                    bad = 1'b1;
                end
            endcase
            if (!bad && item_reg.last_of_read && (phase_next != PH_RUN))
            begin
                bad = 1'b1;
            end
            if (bad)
            begin
                run_next = '0;
                if (item_reg.last_of_read)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    discard_next = 1'b1;
                end
            end
            else if (item_reg.last_of_read)
            begin
                summ       = 1'b1;
                run_next   = '0;
                phase_next = PH_IDLE;
            end
        end
    end

    always_comb
    begin
        push.res_a.kind         = bad ? basp_pkg::KIND_BAD : basp_pkg::KIND_SUMMARY;
        push.res_a.coord_first  = '0;
        push.res_a.coord_second = '0;
        push.res_a.error_count  = err_next;
        push.res_a.intron_count = intr_next;
        push.res_a.mate_one     = mate_next;
        push.res_a.last_of_run  = 1'b1;
        push.res_b              = push.res_a;
        if (rec)
        begin
            push.res_a.kind         = basp_pkg::KIND_INTRON;
            push.res_a.coord_first  = $signed(b1);
            push.res_a.coord_second = $signed(b2);
            push.res_a.last_of_run  = !summ;
        end
        if (!fire)
        begin
            push.count = 2'd0;
        end
        else
        begin
            push.count = {1'b0, rec} + {1'b0, (bad || summ)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            position_reg <= '0;
            run_reg      <= '0;
            err_reg      <= '0;
            intr_reg     <= '0;
            up_reg       <= 1'b0;
            mate_reg     <= 1'b0;
            discard_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            position_reg <= position_next;
            run_reg      <= run_next;
            err_reg      <= err_next;
            intr_reg     <= intr_next;
            up_reg       <= up_next;
            mate_reg     <= mate_next;
            discard_reg  <= discard_next;
        end
    end

endmodule

// ===== rtl/basp_resq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// basp_resq
// Result queue that takes up to two results per cycle and hands out one per
// transaction on the output stream.
// ----------------------------------------------------------------------------
module basp_resq
#(
    parameter int DEPTH = basp_pkg::RESQ_DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  basp_pkg::push_t   push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output basp_pkg::result_t out_res
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

    basp_pkg::result_t entry_reg [DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW-1:0] tail_plus1;
    logic [PW-1:0] tail_plus2;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign pop        = out_valid && out_ready;
    assign out_valid  = (count_reg != '0);
    assign out_res    = entry_reg[head_reg];
    assign room       = (count_reg <= ROOM_MAX);
    assign tail_plus1 = (tail_reg == LAST_IDX) ? '0 : tail_reg + PW'(1);
    assign tail_plus2 = (tail_plus1 == LAST_IDX) ? '0 : tail_plus1 + PW'(1);
    assign head_next  = pop ? ((head_reg == LAST_IDX) ? '0 : head_reg + PW'(1)) : head_reg;
    assign count_next = count_reg + CW'(push.count) - CW'(pop);

    always_comb
    begin
        case (push.count)
            2'd1:    tail_next = tail_plus1;
            2'd2:    tail_next = tail_plus2;
            default: tail_next = tail_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[tail_reg] <= push.res_a;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[tail_plus1] <= push.res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/btop_alignment_string_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btop_alignment_string_parser_core
// Parses alignment trace strings one character per transaction and reports
// intron records, end summaries and malformed strings.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one trace character per transaction; tuser marks
// the first character of a string and tlast the final one. The start
// coordinate, strand and mate flag are sampled with the first character.
// The master stream carries results; tuser gives the kind and tlast marks
// the final result caused by one input character.
// An accepted character waits in the input register until the result queue
// has room; it is then parsed and its results are written into the queue,
// from which they go out on the master stream. One character is accepted
// every cycle as long as the result queue has space for two results; one
// result leaves per cycle while the receiver is ready. When the receiver
// stalls, the queue of RESQ_DEPTH results fills and the slave side then
// deasserts tready until space is free again. Reset clears the parse state,
// empties the queue and disables intron reporting. The intron report
// register may be written on any cycle while no string is in flight.
// ----------------------------------------------------------------------------
module btop_alignment_string_parser_core
#(
    parameter int RESQ_DEPTH = basp_pkg::RESQ_DEPTH_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // symbol[7:0], start_position[38:8], reverse_strand[39], read_is_first[40]
    input  logic [basp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // first_of_read[0]
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // coord_first[31:0], coord_second[63:32], error_count[79:64],
    // intron_count[87:80], mate_one[88]
    output logic [basp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                          m_axis_tuser,
    output logic                                m_axis_tlast
);

    basp_pkg::input_t  in_item;
    basp_pkg::push_t   push;
    basp_pkg::result_t out_res;
    logic              room;

    assign in_item.symbol         = s_axis_tdata[7:0];
    assign in_item.first_of_read  = s_axis_tuser;
    assign in_item.last_of_read   = s_axis_tlast;
    assign in_item.start_position = s_axis_tdata[38:8];
    assign in_item.reverse_strand = s_axis_tdata[39];
    assign in_item.read_is_first  = s_axis_tdata[40];

    basp_step u_step
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_item     (in_item),
        .room        (room),
        .push        (push)
    );

    basp_resq #(.DEPTH(RESQ_DEPTH)) u_resq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {7'd0, out_res.mate_one, out_res.intron_count,
                           out_res.error_count, out_res.coord_second, out_res.coord_first};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last_of_run;

endmodule

// ===== rtl/basp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// basp_checker
// Port-level checks of the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module basp_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [basp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic [1:0]                        m_axis_tuser,
    input logic                              m_axis_tlast
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result valid dropped while stalled.");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("Result payload changed while stalled.");

    a_coords_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != basp_pkg::KIND_INTRON) |->
            (m_axis_tdata[63:0] == 64'd0))
        else $error("Summary or malformed result carries coordinates.");

    a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == basp_pkg::KIND_SUMMARY) ||
                          (m_axis_tuser == basp_pkg::KIND_BAD)) |-> m_axis_tlast)
        else $error("Summary or malformed result is not the final one of its input.");

endmodule

bind btop_alignment_string_parser_core basp_checker u_basp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the alignment trace string parser.
// Directed and random trace strings, both well-formed and broken, are streamed
// in with random bursts and gaps while the result stream stalls on a pattern
// of its own. A predictor follows the parse state and every result
// transaction is checked field by field, in order, against its prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 40;

    typedef enum logic [2:0] {
        P_IDLE,
        P_RUN,
        P_DEL,
        P_INS,
        P_INTRON,
        P_SUB2
    } trace_phase_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [basp_pkg::IN_TDATA_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [basp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic m_axis_tlast;

    basp_pkg::input_t  char_backlog[$];
    basp_pkg::result_t pending_results[$];
    basp_pkg::input_t  drive_char;
    logic              char_taken;

    int chars_queued;
    int chars_accepted;
    int strings_sent;
    int fail_count;
    int cycle_count;
    int intron_records;
    int summaries;
    int malformed;
    int burst_left;
    int gap_left;
    int stall_mode;
    int stall_left;

    trace_phase_t t_phase;
    logic [31:0]  t_pos;
    logic [23:0]  t_run;
    logic [15:0]  t_err;
    logic [7:0]   t_introns;
    logic         t_ascending;
    logic         t_mate;
    logic         t_discard;
    logic         report_en;

    btop_alignment_string_parser_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic digit_char(input logic [7:0] c);
        return (c >= basp_pkg::SYM_ZERO) && (c <= basp_pkg::SYM_NINE);
    endfunction

    function automatic logic base_char(input logic [7:0] c);
        return (c == basp_pkg::SYM_A) || (c == basp_pkg::SYM_T) ||
               (c == basp_pkg::SYM_G) || (c == basp_pkg::SYM_C) ||
               (c == basp_pkg::SYM_N) || (c == basp_pkg::SYM_DASH);
    endfunction

    function automatic logic [31:0] advanced(input logic [31:0] n);
        return t_ascending ? t_pos + n : t_pos - n;
    endfunction

    function automatic void take_digit(input logic [7:0] c);
        logic [31:0] d;
        d = {24'd0, c} - {24'd0, basp_pkg::SYM_ZERO};
        if ({8'd0, t_run} > (32'h00FF_FFFF - d) / 32'd10)
            t_run = basp_pkg::RUN_MAX;
        else
            t_run = 24'({8'd0, t_run} * 32'd10 + d);
    endfunction

    function automatic void add_errors(input logic [31:0] n);
        logic [31:0] sum;
        sum = {16'd0, t_err} +
              ((n > {16'd0, basp_pkg::ERR_MAX}) ? {16'd0, basp_pkg::ERR_MAX} : n);
        t_err = (sum > {16'd0, basp_pkg::ERR_MAX}) ? basp_pkg::ERR_MAX : sum[15:0];
    endfunction

    function automatic basp_pkg::result_t make_result(input logic [1:0] kind,
                                                      input logic [31:0] c1,
                                                      input logic [31:0] c2);
        basp_pkg::result_t r;
        r.kind         = kind;
        r.coord_first  = c1;
        r.coord_second = c2;
        r.error_count  = t_err;
        r.intron_count = t_introns;
        r.mate_one     = t_mate;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    function automatic void parse_char(input basp_pkg::input_t c);
        basp_pkg::result_t outs [2];
        int          k;
        logic        bad;
        logic [31:0] far_end;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] swap;
        k   = 0;
        bad = 1'b0;
        if (c.first_of_read)
        begin
            t_pos       = {1'b0, c.start_position};
            t_ascending = !c.reverse_strand;
            t_mate      = c.read_is_first;
            t_err       = '0;
            t_introns   = '0;
            t_run       = '0;
            t_discard   = 1'b0;
            t_phase     = P_RUN;
        end
        if (t_phase == P_IDLE)
            return;
        if (t_discard)
        begin
            if (c.last_of_read)
            begin
                t_phase   = P_IDLE;
                t_discard = 1'b0;
            end
            return;
        end
        case (t_phase)
            P_RUN:
            begin
                if (digit_char(c.symbol))
                    take_digit(c.symbol);
                else
                begin
                    t_pos = advanced({8'd0, t_run});
                    t_run = '0;
                    if (c.symbol == basp_pkg::SYM_PCT)
                        t_phase = P_DEL;
                    else if (c.symbol == basp_pkg::SYM_UNDER)
                        t_phase = P_INS;
                    else if (c.symbol == basp_pkg::SYM_CARET)
                        t_phase = P_INTRON;
                    else if (base_char(c.symbol))
                        t_phase = P_SUB2;
                    else
                        bad = 1'b1;
                end
            end
            P_DEL:
            begin
                if (digit_char(c.symbol))
                    take_digit(c.symbol);
                else if (c.symbol == basp_pkg::SYM_PCT)
                begin
                    t_run   = '0;
                    t_phase = P_RUN;
                end
                else
                    bad = 1'b1;
            end
            P_INS:
            begin
                if (digit_char(c.symbol))
                    take_digit(c.symbol);
                else if (c.symbol == basp_pkg::SYM_UNDER)
                begin
                    add_errors({8'd0, t_run});
                    t_pos   = advanced({8'd0, t_run});
                    t_run   = '0;
                    t_phase = P_RUN;
                end
                else
                    bad = 1'b1;
            end
            P_INTRON:
            begin
                if (digit_char(c.symbol))
                    take_digit(c.symbol);
                else if (c.symbol == basp_pkg::SYM_CARET)
                begin
                    far_end = advanced({8'd0, t_run});
                    b1      = t_pos;
                    b2      = t_ascending ? far_end - 32'd1 : far_end + 32'd1;
                    if (t_mate)
                    begin
                        swap = b1;
                        b1   = b2;
                        b2   = swap;
                    end
                    if (t_introns < basp_pkg::INTR_MAX)
                        t_introns++;
                    if (report_en)
                    begin
                        outs[k] = make_result(basp_pkg::KIND_INTRON, b1, b2);
                        k++;
                    end
                    t_pos   = far_end;
                    t_run   = '0;
                    t_phase = P_RUN;
                end
                else
                    bad = 1'b1;
            end
            P_SUB2:
            begin
                if (base_char(c.symbol))
                begin
                    add_errors(32'd1);
                    t_pos   = advanced(32'd1);
                    t_phase = P_RUN;
                end
                else
                    bad = 1'b1;
            end
            default: bad = 1'b1;
        endcase
        if (!bad && c.last_of_read && t_phase != P_RUN)
            bad = 1'b1;
        if (bad)
        begin
            outs[k] = make_result(basp_pkg::KIND_BAD, 32'd0, 32'd0);
            k++;
            t_run = '0;
            if (c.last_of_read)
                t_phase = P_IDLE;
            else
                t_discard = 1'b1;
        end
        else if (c.last_of_read)
        begin
            outs[k] = make_result(basp_pkg::KIND_SUMMARY, 32'd0, 32'd0);
            k++;
            t_run   = '0;
            t_phase = P_IDLE;
        end
        if (k > 0)
            outs[k-1].last_of_run = 1'b1;
        for (int i = 0; i < k; i++)
            pending_results.push_back(outs[i]);
    endfunction

    // ------------------------------------------------------------------
    // Driver and receiver
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || char_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (char_backlog.size() > 0)
            begin
                drive_char = char_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, drive_char.read_is_first, drive_char.reverse_strand,
                                  drive_char.start_position, drive_char.symbol};
                s_axis_tuser  <= drive_char.first_of_read;
                s_axis_tlast  <= drive_char.last_of_read;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(4, 48);
            end
            else
                stall_left--;
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        basp_pkg::result_t want;
        char_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (char_taken)
        begin
            parse_char(drive_char);
            chars_accepted++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t ns: unexpected result, expected none, actual kind %0d",
                             $time, m_axis_tuser);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("coord_first", 32'(want.coord_first), m_axis_tdata[31:0]);
                check_field("coord_second", 32'(want.coord_second), m_axis_tdata[63:32]);
                check_field("error_count", 32'(want.error_count), 32'(m_axis_tdata[79:64]));
                check_field("intron_count", 32'(want.intron_count),
                            32'(m_axis_tdata[87:80]));
                check_field("mate_one", 32'(want.mate_one), 32'(m_axis_tdata[88]));
                check_field("last_of_run", 32'(want.last_of_run), 32'(m_axis_tlast));
                if (want.kind == basp_pkg::KIND_INTRON)
                    intron_records++;
                else if (want.kind == basp_pkg::KIND_SUMMARY)
                    summaries++;
                else
                    malformed++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("btop_alignment_string_parser_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_base();
        case ($urandom_range(0, 5))
            0: return basp_pkg::SYM_A;
            1: return basp_pkg::SYM_T;
            2: return basp_pkg::SYM_G;
            3: return basp_pkg::SYM_C;
            4: return basp_pkg::SYM_N;
            default: return basp_pkg::SYM_DASH;
        endcase
    endfunction

    function automatic logic [7:0] pick_opener();
        case ($urandom_range(0, 2))
            0: return basp_pkg::SYM_PCT;
            1: return basp_pkg::SYM_UNDER;
            default: return basp_pkg::SYM_CARET;
        endcase
    endfunction

    function automatic logic [30:0] pick_start();
        case ($urandom_range(0, 7))
            0: return 31'd1;
            1: return 31'h7FFF_FFFF;
            default: return 31'($urandom_range(1, 32'h7FFF_FFFF));
        endcase
    endfunction

    function automatic int digit_count();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(6, 9);
        return $urandom_range(0, 3);
    endfunction

    task automatic queue_char(input logic [7:0] sym, input logic first, input logic last,
                              input logic [30:0] start, input logic rev, input logic mate);
        basp_pkg::input_t c;
        c.symbol         = sym;
        c.first_of_read  = first;
        c.last_of_read   = last;
        c.start_position = start;
        c.reverse_strand = rev;
        c.read_is_first  = mate;
        char_backlog.push_back(c);
        chars_queued++;
    endtask

    // Only the first character carries a meaningful start, strand and mate;
    // the others get random values there, which the parser must ignore.
    task automatic send_trace(input logic [7:0] q[$], input logic close,
                              input logic [30:0] start, input logic rev, input logic mate);
        for (int i = 0; i < q.size(); i++)
        begin
            if (i == 0)
                queue_char(q[i], 1'b1, close && q.size() == 1, start, rev, mate);
            else
                queue_char(q[i], 1'b0, close && i == q.size() - 1, 31'($urandom),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        strings_sent++;
    endtask

    task automatic send_text(input string text, input logic close,
                             input logic [30:0] start, input logic rev, input logic mate);
        logic [7:0] q[$];
        for (int i = 0; i < text.len(); i++)
            q.push_back(text[i]);
        send_trace(q, close, start, rev, mate);
    endtask

    task automatic append_digits(ref logic [7:0] q[$], input int count);
        for (int i = 0; i < count; i++)
            q.push_back(basp_pkg::SYM_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic build_trace(ref logic [7:0] q[$]);
        int tokens;
        q.delete();
        tokens = $urandom_range(1, 8);
        for (int t = 0; t < tokens; t++)
        begin
            case ($urandom_range(0, 5))
                0, 1: append_digits(q, digit_count() + 1);
                2:
                begin
                    q.push_back(basp_pkg::SYM_PCT);
                    append_digits(q, digit_count());
                    q.push_back(basp_pkg::SYM_PCT);
                end
                3:
                begin
                    q.push_back(basp_pkg::SYM_UNDER);
                    append_digits(q, digit_count());
                    q.push_back(basp_pkg::SYM_UNDER);
                end
                4:
                begin
                    q.push_back(basp_pkg::SYM_CARET);
                    append_digits(q, digit_count());
                    q.push_back(basp_pkg::SYM_CARET);
                end
                default:
                begin
                    q.push_back(pick_base());
                    q.push_back(pick_base());
                end
            endcase
        end
    endtask

    task automatic mangle_trace(ref logic [7:0] q[$]);
        int cut;
        case ($urandom_range(0, 3))
            0: q.insert($urandom_range(0, q.size() - 1), 8'($urandom_range(0, 255)));
            1:
            begin
                if (q.size() > 1)
                begin
                    cut = $urandom_range(1, q.size() - 1);
                    while (q.size() > cut)
                        void'(q.pop_back());
                end
            end
            2: q.push_back(pick_base());
            default:
            begin
                q.push_back(pick_opener());
                append_digits(q, digit_count());
            end
        endcase
    endtask

    // Mostly well-formed strings with random content, plus corrupted,
    // unterminated strings and stray characters between strings.
    task automatic random_traces(input int char_budget);
        logic [7:0] q[$];
        int used;
        int roll;
        used = 0;
        while (used < char_budget)
        begin
            build_trace(q);
            roll = $urandom_range(0, 99);
            if (roll < 15)
                mangle_trace(q);
            send_trace(q, !(roll >= 15 && roll < 21), pick_start(),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            used += q.size();
            if (roll >= 21 && $urandom_range(0, 7) == 0)
            begin
                for (int i = $urandom_range(1, 3); i > 0; i--)
                    queue_char(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                               31'($urandom), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
            end
        end
        build_trace(q);
        send_trace(q, 1'b1, pick_start(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_drained();
        while (chars_accepted != chars_queued || pending_results.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_report_enable(input logic value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        report_en    = value;
        @(posedge clk);
    endtask

    // A stray digit outside any string must be ignored by the parser.
    function automatic logic [7:0] SYM_SEVEN_OR_DIGIT();
        return basp_pkg::SYM_ZERO + 8'd7;
    endfunction

    initial
    begin
        logic [7:0] q[$];
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        char_taken    = 1'b0;
        burst_left    = 1;
        gap_left      = 0;
        stall_mode    = 0;
        stall_left    = 0;
        t_phase       = P_IDLE;
        t_pos         = '0;
        t_run         = '0;
        t_err         = '0;
        t_introns     = '0;
        t_ascending   = 1'b0;
        t_mate        = 1'b0;
        t_discard     = 1'b0;
        report_en     = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_report_enable(1'b1);
        send_text("12^7^3", 1'b1, 31'h7FFF_FFFF, 1'b0, 1'b0);
        send_text("^5^AG", 1'b1, 31'd1, 1'b1, 1'b1);
        send_text("_3_%2%", 1'b1, 31'd1000, 1'b0, 1'b0);
        queue_char(SYM_SEVEN_OR_DIGIT(), 1'b0, 1'b1, 31'd5, 1'b0, 1'b0);
        queue_char(8'h00, 1'b1, 1'b1, 31'd77, 1'b1, 1'b0);
        send_text("4A", 1'b1, 31'd300, 1'b1, 1'b0);
        send_text("3^", 1'b0, 31'd40, 1'b0, 1'b1);
        send_text("9", 1'b1, 31'd50, 1'b1, 1'b1);
        send_text("X12", 1'b1, 31'd60, 1'b0, 1'b0);

        write_report_enable(1'b0);
        random_traces(220);

        write_report_enable(1'b1);
        q.delete();
        for (int i = 0; i < 260; i++)
        begin
            q.push_back(basp_pkg::SYM_CARET);
            q.push_back(basp_pkg::SYM_CARET);
        end
        q.push_back(basp_pkg::SYM_ZERO + 8'd5);
        send_trace(q, 1'b1, 31'd123456, 1'b1, 1'b0);
        random_traces(220);

        write_report_enable(1'b0);
        send_text("_70000__70000_AC", 1'b1, 31'd9, 1'b0, 1'b1);
        random_traces(220);

        wait_drained();
        $display("Checked %0d results (%0d intron records, %0d summaries, %0d malformed)",
                 intron_records + summaries + malformed, intron_records, summaries, malformed);
        $display("from %0d characters in %0d strings, intron reporting toggled both ways.",
                 chars_accepted, strings_sent);
        if (fail_count == 0)
            $display("btop_alignment_string_parser_core verification clean");
        else
            $display("btop_alignment_string_parser_core verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/basp_pkg.sv
rtl/basp_step.sv
rtl/basp_resq.sv
rtl/btop_alignment_string_parser_core.sv
rtl/basp_checker.sv
tb/tb_top.sv
